// File: rtl/twt_pkg.sv
// Package: shared types and constants for the text word tokenizer.
package twt_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 8;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'd9;

    localparam logic [LEN_W-1:0] MAX_WORD_RESET = 8'd99;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_END_WORD = 2'd1,
        KIND_END_SENT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] ch;
        logic              trunc;
    } t_token;

    // One queue entry holds every token one input word causes.
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_entry;

endpackage

// File: rtl/twt_in_if.sv
// Interface: input word channel (text byte and end-of-stream flag).
interface twt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_final;

    modport source (output valid, output text_byte, output is_final, input ready);
    modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface

// File: rtl/twt_out_if.sv
// Interface: output token channel.
interface twt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] token_kind;
    logic [7:0] char_value;
    logic       was_truncated;
    logic       last_of_run;

    modport source (output valid, output token_kind, output char_value,
                    output was_truncated, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input char_value,
                    input was_truncated, input last_of_run, output ready);
endinterface

// File: rtl/twt_front.sv
// Front end: classify each byte, track word state, build queue entries.
module twt_front
    import twt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_data,
    twt_in_if.sink            i_in,
    input  logic              i_full,
    output logic              o_push,
    output t_entry            o_entry
);

    logic [LEN_W-1:0] r_max_chars, n_max_chars;
    logic [LEN_W-1:0] r_word_len,  n_word_len;
    logic             r_skip,      n_skip;
    logic [LEN_W-1:0] len_inc;
    logic [1:0]       tok_cnt;
    t_token           tok0, tok1;
    logic             accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign len_inc    = r_word_len + LEN_W'(1);

    always_comb begin
        n_word_len = r_word_len;
        n_skip     = r_skip;
        tok_cnt    = 2'd0;
        tok0       = '{kind: KIND_CHAR, ch: '0, trunc: 1'b0};
        tok1       = '{kind: KIND_CHAR, ch: '0, trunc: 1'b0};

        if (i_in.text_byte == CH_CR) begin
            // drop
        end else if (i_in.text_byte == CH_LF) begin
            if (r_word_len != '0) begin
                tok0.kind = KIND_END_WORD;
                tok1.kind = KIND_END_SENT;
                tok_cnt   = 2'd2;
            end else begin
                tok0.kind = KIND_END_SENT;
                tok_cnt   = 2'd1;
            end
            n_word_len = '0;
            n_skip     = 1'b0;
        end else if (i_in.text_byte == CH_SP || i_in.text_byte == CH_TAB) begin
            if (r_word_len != '0) begin
                tok0.kind = KIND_END_WORD;
                tok_cnt   = 2'd1;
            end
            n_word_len = '0;
            n_skip     = 1'b0;
        end else if (!r_skip) begin
            tok0.kind = KIND_CHAR;
            tok0.ch   = i_in.text_byte;
            if (len_inc >= r_max_chars) begin
                // word full: close it flagged, then drop up to the next delimiter
                tok1.kind  = KIND_END_WORD;
                tok1.trunc = 1'b1;
                tok_cnt    = 2'd2;
                n_word_len = '0;
                n_skip     = 1'b1;
            end else begin
                tok_cnt    = 2'd1;
                n_word_len = len_inc;
            end
        end

        if (i_in.is_final) begin
            if (n_word_len != '0) begin
                if (tok_cnt == 2'd0) begin
                    tok0.kind = KIND_END_WORD;
                end else begin
                    tok1.kind = KIND_END_WORD;
                end
                tok_cnt = tok_cnt + 2'd1;
            end
            n_word_len = '0;
            n_skip     = 1'b0;
        end
    end

    assign n_max_chars = i_cfg_we ? i_cfg_data : r_max_chars;

    assign o_push       = accept && (tok_cnt != 2'd0);
    assign o_entry.two  = (tok_cnt == 2'd2);
    assign o_entry.tok0 = tok0;
    assign o_entry.tok1 = tok1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= MAX_WORD_RESET;
            r_word_len  <= '0;
            r_skip      <= 1'b0;
        end else begin
            r_max_chars <= n_max_chars;
            if (accept) begin
                r_word_len <= n_word_len;
                r_skip     <= n_skip;
            end
        end
    end

endmodule

// File: rtl/twt_fifo.sv
// Short entry queue between the front end and the back end.
module twt_fifo
    import twt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_push_data,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: rtl/twt_back.sv
// Back end: unpack queue entries into one token per output word.
module twt_back
    import twt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_empty,
    input  t_entry i_head,
    output logic   o_pop,
    twt_out_if.source o_out
);

    logic   r_sel, n_sel;
    logic   last;
    logic   take;
    t_token tok;

    assign tok  = r_sel ? i_head.tok1 : i_head.tok0;
    assign last = i_head.two ? r_sel : 1'b1;
    assign take = o_out.valid && o_out.ready;

    assign o_out.valid         = !i_empty;
    assign o_out.token_kind    = tok.kind;
    assign o_out.char_value    = tok.ch;
    assign o_out.was_truncated = tok.trunc;
    assign o_out.last_of_run   = last;

    // release the entry after its final token goes out
    assign o_pop = take && last;

    always_comb begin
        n_sel = r_sel;
        if (take) begin
            n_sel = !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else begin
            r_sel <= n_sel;
        end
    end

endmodule

// File: rtl/text_word_tokenizer_unit.sv
// Top level: whitespace word tokenizer with decoupled front end and back end.
//
//  Channel   Dir  Handshake       Payload
//  i_in      in   valid/ready     text_byte[7:0], is_final
//  o_out     out  valid/ready     token_kind[1:0], char_value[7:0],
//                                 was_truncated, last_of_run
//  cfg       in   i_cfg_we        i_cfg_data[7:0] (max_word_chars)
//
// Input takes one word per cycle while the entry queue has room.
// Output gives one token per cycle while the queue has an entry and o_out is
// ready; a byte that causes two tokens holds the queue head until both go out,
// so the output side sets the long-run rate. Tokens pass the queue register.
// Synchronous active-low reset clears state, queue and sets the limit to 99.
// Either side may stall at any time; the four-entry queue absorbs the skew.
module text_word_tokenizer_unit
    import twt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data,
    twt_in_if.sink           i_in,
    twt_out_if.source        o_out
);

    logic   push, pop, full, empty;
    t_entry push_data, head;

    twt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (push_data)
    );

    twt_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_full      (full),
        .o_empty     (empty),
        .o_head      (head)
    );

    twt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
